// ===== src/cdar_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cdar_pkg: shared types and constants of the captive DNS answer rewriter
// Beat payloads, the front-to-back command word and sizing helpers.
// ----------------------------------------------------------------------------
package cdar_pkg;

  localparam int BufBytesDef  = 256;
  localparam int WalkLimitDef = 200;
  localparam int CmdDepthDef  = 4;

  // answer record: 16 bytes after the question
  localparam int AnsBytes = 16;
  localparam logic [31:0] NetMask = 32'hFFFF_FF00;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic        rx_last;
    logic [31:0] src_addr;
  } rx_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_last;
    logic       tx_discard;
  } tx_item_t;

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_DISCARD,
    CMD_ANSWER
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic       has_byte;
    logic [7:0] data;
  } cmd_t;

  // position width: enough for the furthest label end plus the record
  function automatic int pos_width(int buf_bytes, int walk_limit);
    int top;
    top = (buf_bytes > walk_limit + 256) ? buf_bytes : walk_limit + 256;
    return $clog2(top + AnsBytes + 6) + 1;
  endfunction

endpackage
`default_nettype wire

// ===== src/cdar_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cdar_front: query parser
// Tracks position, header checks and the label walk; issues one command per
// beat that produces output.
// ----------------------------------------------------------------------------
module cdar_front import cdar_pkg::*; #(
  parameter int BUF_BYTES  = BufBytesDef,
  parameter int WALK_LIMIT = WalkLimitDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire rx_item_t    rx_i,
  input  wire logic [31:0] portal_net_i,
  output logic             cmd_valid_o,
  output cmd_t             cmd_o
);

  localparam int PW = pos_width(BUF_BYTES, WALK_LIMIT);
  localparam logic [PW-1:0] PosStart = PW'(12);
  localparam logic [PW-1:0] PosFlagsHi = PW'(2);
  localparam logic [PW-1:0] PosFlagsLo = PW'(3);
  localparam logic [PW-1:0] PosQdHi    = PW'(4);
  localparam logic [PW-1:0] PosQdLo    = PW'(5);
  localparam logic [PW-1:0] PosAnHi    = PW'(6);
  localparam logic [PW-1:0] PosAnLo    = PW'(7);
  localparam logic [PW-1:0] PosArLo    = PW'(11);

  logic [PW-1:0] cnt_q, cnt_d, nlp_q, nlp_d, qe_q, qe_d;
  logic          wd_q, wd_d, hok_q, hok_d;
  logic [7:0]    chb_q, chb_d;

  logic [PW-1:0] pos, nlp_add, pend;
  logic [7:0]    b, wr_byte;
  logic          inbuf, hit, emit, ok;

  function automatic logic [7:0] rewrite(logic [PW-1:0] p, logic [7:0] v);
    logic [7:0] r;
    r = v;
    if (p == PosFlagsHi) r = 8'h81;
    else if (p == PosFlagsLo) r = 8'h80;
    else if (p == PosAnLo) r = 8'h01;
    else if (p == PosAnHi || (p > PosAnLo && p <= PosArLo)) r = 8'h00;
    return r;
  endfunction

  always_comb begin
    b       = rx_i.rx_byte;
    pos     = cnt_q;
    inbuf   = pos < PW'(BUF_BYTES);
    nlp_add = nlp_q + PW'(b) + PW'(1);
    wr_byte = rewrite(pos, b);

    hok_d = hok_q;
    chb_d = chb_q;
    nlp_d = nlp_q;
    qe_d  = qe_q;
    wd_d  = wd_q;
    cnt_d = cnt_q;
    if (inbuf) begin
      if (pos == '0 && ((rx_i.src_addr ^ portal_net_i) & NetMask) != '0) hok_d = 1'b0;
      if (pos == PosFlagsHi && b[7]) hok_d = 1'b0;
      if (pos == PosQdHi) chb_d = b;
      if (pos == PosQdLo && (chb_q != 8'd0 || b != 8'd1)) hok_d = 1'b0;
      cnt_d = pos + PW'(1);
    end

    hit = inbuf && !wd_q && pos == nlp_q;
    if (hit) begin
      if (b == 8'd0) begin
        wd_d = 1'b1;
        qe_d = pos + PW'(5);
      end else begin
        nlp_d = nlp_add;
        if (nlp_add > PW'(WALK_LIMIT)) begin
          wd_d = 1'b1;
          qe_d = nlp_add + PW'(5);
        end
      end
    end

    emit = inbuf && (!wd_d || pos < qe_d);
    pend = wd_d ? qe_d : nlp_d + PW'(5);
    ok   = cnt_d >= PosStart && hok_d && pend <= cnt_d
           && (pend + PW'(AnsBytes)) <= PW'(BUF_BYTES);

    cmd_o.data     = wr_byte;
    cmd_o.has_byte = 1'b1;
    cmd_o.kind     = CMD_BYTE;
    cmd_valid_o    = accept_i && emit;
    if (rx_i.rx_last) begin
      cmd_valid_o = accept_i;
      if (!ok) begin
        cmd_o.kind     = CMD_DISCARD;
        cmd_o.has_byte = 1'b0;
      end else begin
        cmd_o.kind     = CMD_ANSWER;
        cmd_o.has_byte = inbuf && pos < pend;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      nlp_q <= PosStart;
      qe_q  <= '0;
      wd_q  <= 1'b0;
      hok_q <= 1'b1;
      chb_q <= '0;
    end else if (accept_i) begin
      if (rx_i.rx_last) begin
        cnt_q <= '0;
        nlp_q <= PosStart;
        qe_q  <= '0;
        wd_q  <= 1'b0;
        hok_q <= 1'b1;
        chb_q <= '0;
      end else begin
        cnt_q <= cnt_d;
        nlp_q <= nlp_d;
        qe_q  <= qe_d;
        wd_q  <= wd_d;
        hok_q <= hok_d;
        chb_q <= chb_d;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/cdar_cmd_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cdar_cmd_fifo: command queue
// Short queue between the parser and the emitter.
// ----------------------------------------------------------------------------
module cdar_cmd_fifo import cdar_pkg::*; #(
  parameter int DEPTH = CmdDepthDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t data_i,
  input  wire logic pop_i,
  output cmd_t      data_o,
  output logic      full_o,
  output logic      empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = cnt_q == CW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
      if (pop_i) rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
      if (push_i && !pop_i) cnt_q <= cnt_q + CW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CW'(1);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i)) else $error("command queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o)) else $error("command queue underflow");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH)) else $error("command queue count out of range");
`endif

endmodule
`default_nettype wire

// ===== src/cdar_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cdar_back: response emitter
// Turns commands into result beats and appends the A record.
// ----------------------------------------------------------------------------
module cdar_back import cdar_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  input  wire logic        cmd_empty_i,
  output logic             cmd_pop_o,
  input  wire logic [31:0] portal_net_i,
  input  wire logic        pop_i,
  output logic             valid_o,
  output tx_item_t         tx_o
);

  localparam int IW = $clog2(AnsBytes);
  localparam logic [IW-1:0] IdxLast = IW'(AnsBytes - 1);

  logic          out_valid_q;
  tx_item_t      out_q, nxt;
  logic          have, load;
  logic          ans_act_q;
  logic [IW-1:0] ans_idx_q;
  logic [31:0]   ip;

  // A record: ptr C0 0C, type A, class IN, TTL 60, rdlength 4, address
  function automatic logic [7:0] rec(logic [IW-1:0] i, logic [31:0] a);
    logic [7:0] r;
    unique case (i)
      4'd0:    r = 8'hC0;
      4'd1:    r = 8'h0C;
      4'd3:    r = 8'h01;
      4'd5:    r = 8'h01;
      4'd9:    r = 8'd60;
      4'd11:   r = 8'h04;
      4'd12:   r = a[31:24];
      4'd13:   r = a[23:16];
      4'd14:   r = a[15:8];
      4'd15:   r = a[7:0];
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  assign ip      = portal_net_i | 32'd1;
  assign load    = !out_valid_q || pop_i;
  assign valid_o = out_valid_q;
  assign tx_o    = out_q;

  always_comb begin
    have      = 1'b0;
    nxt       = '0;
    cmd_pop_o = 1'b0;
    if (ans_act_q) begin
      have        = 1'b1;
      nxt.tx_byte = rec(ans_idx_q, ip);
      nxt.tx_last = ans_idx_q == IdxLast;
    end else if (!cmd_empty_i) begin
      have      = 1'b1;
      cmd_pop_o = load;
      unique case (cmd_i.kind)
        CMD_BYTE: nxt.tx_byte = cmd_i.data;
        CMD_DISCARD: begin
          nxt.tx_last    = 1'b1;
          nxt.tx_discard = 1'b1;
        end
        CMD_ANSWER: nxt.tx_byte = cmd_i.has_byte ? cmd_i.data : rec('0, ip);
        default: nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) out_q <= nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      ans_act_q   <= 1'b0;
      ans_idx_q   <= '0;
    end else if (load) begin
      out_valid_q <= have;
      if (ans_act_q) begin
        if (ans_idx_q == IdxLast) ans_act_q <= 1'b0;
        ans_idx_q <= ans_idx_q + IW'(1);
      end else if (cmd_pop_o && cmd_i.kind == CMD_ANSWER) begin
        ans_act_q <= 1'b1;
        ans_idx_q <= cmd_i.has_byte ? '0 : IW'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_discard_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.tx_discard |-> out_q.tx_last && out_q.tx_byte == 8'h00)
    else $error("malformed discard beat");
  a_no_pop_in_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ans_act_q |-> !cmd_pop_o) else $error("command taken during answer");
  a_answer_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ans_act_q && load && ans_idx_q == IdxLast |=> !ans_act_q && out_q.tx_last)
    else $error("answer record did not close");
`endif

endmodule
`default_nettype wire

// ===== src/captive_dns_answer_rewriter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// captive_dns_answer_rewriter: captive portal DNS responder
// Rewrites a query byte stream into a response answering with the hotspot.
// ----------------------------------------------------------------------------
// Feed a DNS query one beat per byte on rx_i (rx_last on the final byte) and
// read the response from tx_o. Header bytes are patched into a response
// header, question bytes pass through, and after the last byte a 16-byte A
// record for portal_net|1 (TTL 60) follows, tx_last on its final byte. If the
// sender is outside the portal /24, the header is not a plain one-question
// query, or the question runs past the datagram or buffer, the datagram ends
// with a single discard beat instead (tx_discard=1): drop whatever was already
// sent for it. Bytes past BUF_BYTES are ignored. Rate: the parser takes one
// byte per cycle while the command queue is not full. The emitter is the
// limit: a queue of CMD_DEPTH commands lets the parser run ahead, so the next
// datagram's bytes are taken while an answer drains, and full only rises once
// the queue fills. The user must see that portal_net is written with cfg_we_i
// only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module captive_dns_answer_rewriter import cdar_pkg::*; #(
  parameter int BUF_BYTES  = BufBytesDef,
  parameter int WALK_LIMIT = WalkLimitDef,
  parameter int CMD_DEPTH  = CmdDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        push,
  output logic             full,
  input  wire rx_item_t    rx_i,
  output logic             empty,
  input  wire logic        pop,
  output tx_item_t         tx_o
);

  logic [31:0] portal_net_q;
  logic        accept, cmd_valid, cmd_pop, cmd_empty, out_valid;
  cmd_t        cmd_in, cmd_out;

  // hotspot network register, reset to 192.168.4.0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      portal_net_q <= 32'hC0A8_0400;
    end else if (cfg_we_i) begin
      portal_net_q <= cfg_wdata_i;
    end
  end

  assign accept = push && !full;

  // parser: checks and label walk, one command per productive beat
  cdar_front #(
    .BUF_BYTES  (BUF_BYTES),
    .WALK_LIMIT (WALK_LIMIT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .rx_i         (rx_i),
    .portal_net_i (portal_net_q),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd_in)
  );

  // decoupling queue; its fill level is the input back-pressure
  cdar_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_valid),
    .data_i  (cmd_in),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .full_o  (full),
    .empty_o (cmd_empty)
  );

  // emitter with registered output beat
  cdar_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_out),
    .cmd_empty_i  (cmd_empty),
    .cmd_pop_o    (cmd_pop),
    .portal_net_i (portal_net_q),
    .pop_i        (pop),
    .valid_o      (out_valid),
    .tx_o         (tx_o)
  );

  assign empty = !out_valid;

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the captive DNS answer rewriter
// Streams DNS queries, well-formed ones and damaged ones, into the block at
// random rates and checks every response beat against a cycle-free predictor.
// The hotspot network is changed between phases, and the extremes are used.
// ----------------------------------------------------------------------------
module tb_top;
  import cdar_pkg::*;

  localparam int BUF_BYTES     = 256;
  localparam int WALK_LIMIT    = 200;
  localparam int PHASE_ITEMS   = 20;      // 4 phases plus the long query, ~420 bytes
  localparam int SETTLE_CYCLES = 16;      // command queue plus a full answer
  localparam int DRAIN_CYCLES  = 32;
  localparam int HOLD_CYCLES   = 240;     // long receiver hold-off
  localparam int RUN_LIMIT_NS  = 2_000_000;
  localparam int MAX_PRINTS    = 100;

  localparam logic [31:0] NET_RESET   = 32'hC0A8_0400;
  localparam logic [31:0] SENDER_MASK = 32'hFFFF_FF00;

  // header patch values and the fixed parts of the A record
  localparam logic [7:0] FLAGS_HI   = 8'h81;
  localparam logic [7:0] FLAGS_LO   = 8'h80;
  localparam logic [7:0] ANCOUNT_LO = 8'h01;
  localparam logic [7:0] NAME_PTR_HI = 8'hC0;
  localparam logic [7:0] NAME_PTR_LO = 8'h0C;
  localparam logic [7:0] TTL_SECONDS = 8'd60;
  localparam logic [7:0] RDLENGTH_A  = 8'd4;

  localparam tx_item_t DISCARD_BEAT = '{tx_byte: 8'h00, tx_last: 1'b1, tx_discard: 1'b1};

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  typedef enum int {
    DG_GOOD,
    DG_FOREIGN_SRC,
    DG_RESP_BIT,
    DG_BAD_COUNT,
    DG_TRUNCATED,
    DG_SHORT,
    DG_LIMIT_SHORT,
    DG_NOISE,
    DG_WALK_BIG
  } dg_kind_e;

  typedef struct packed {
    rx_item_t item;
    logic     want_discard;
  } dir_row_t;

  // Directed part. want_discard rows close on a plain discard beat; all
  // other rows are left to the predictor. Network is still at reset value.
  localparam int DIR_N = 20;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // one-byte datagram, far too short for a header
    '{'{8'h00, 1'b1, 32'hC0A8_0401}, 1'b1},
    // all-ones sender: first byte still streams, close is a discard
    '{'{8'hFF, 1'b0, 32'hFFFF_FFFF}, 1'b0},
    '{'{8'h00, 1'b1, 32'h0000_0000}, 1'b1},
    // root query from the top of the portal /24, header bytes at extremes
    '{'{8'hFF, 1'b0, 32'hC0A8_04FF}, 1'b0},
    '{'{8'h00, 1'b0, 32'h0000_0000}, 1'b0},
    '{'{8'h7F, 1'b0, 32'hFFFF_FFFF}, 1'b0},
    '{'{8'hFF, 1'b0, 32'h0000_0000}, 1'b0},
    '{'{8'h00, 1'b0, 32'hFFFF_FFFF}, 1'b0},
    '{'{8'h01, 1'b0, 32'h0000_0000}, 1'b0},
    '{'{8'hFF, 1'b0, 32'hFFFF_FFFF}, 1'b0},
    '{'{8'hFF, 1'b0, 32'h0000_0000}, 1'b0},
    '{'{8'hFF, 1'b0, 32'hFFFF_FFFF}, 1'b0},
    '{'{8'hFF, 1'b0, 32'h0000_0000}, 1'b0},
    '{'{8'hFF, 1'b0, 32'hFFFF_FFFF}, 1'b0},
    '{'{8'hFF, 1'b0, 32'h0000_0000}, 1'b0},
    '{'{8'h00, 1'b0, 32'hFFFF_FFFF}, 1'b0},   // empty name ends the walk
    '{'{8'h00, 1'b0, 32'h0000_0000}, 1'b0},
    '{'{8'h01, 1'b0, 32'hFFFF_FFFF}, 1'b0},
    '{'{8'hFF, 1'b0, 32'h0000_0000}, 1'b0},
    '{'{8'h01, 1'b1, 32'hFFFF_FFFF}, 1'b0}    // last byte, then the record
  };

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic        push;
  logic        full;
  rx_item_t    rx_i;
  logic        empty;
  logic        pop;
  tx_item_t    tx_o;

  captive_dns_answer_rewriter #(
    .BUF_BYTES (BUF_BYTES),
    .WALK_LIMIT(WALK_LIMIT)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push       (push),
    .full       (full),
    .rx_i       (rx_i),
    .empty      (empty),
    .pop        (pop),
    .tx_o       (tx_o)
  );

  // Predictor state: own copy of the network and the per-datagram parse
  logic [31:0] net_cfg   = NET_RESET;
  logic [8:0]  dg_len    = '0;
  logic [8:0]  label_pos = 9'd12;
  logic [8:0]  q_end     = '0;
  logic        walk_fin  = 1'b0;
  logic        hdr_good  = 1'b1;
  logic [7:0]  qd_hi     = '0;

  tx_item_t   answer_q [$];
  int         mismatches = 0;
  int         items_sent = 0;
  int         hold_req   = 0;
  idle_mode_e idle_mode  = IDLE_NONE;

  always #4 clk_i = ~clk_i;

  initial begin
    #(RUN_LIMIT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("mismatch @%0t: %s", $time, what);
  endtask

  function automatic logic [7:0] patch_header(input logic [8:0] pos, input logic [7:0] b);
    case (pos)
      9'd2: return FLAGS_HI;
      9'd3: return FLAGS_LO;
      9'd7: return ANCOUNT_LO;
      9'd6, 9'd8, 9'd9, 9'd10, 9'd11: return 8'h00;
      default: return b;
    endcase
  endfunction

  // Works out the beats one accepted query byte causes; keep=0 only advances
  // the parse (the directed table supplies the beat itself).
  function automatic void predict_response(input rx_item_t it, input logic keep);
    logic [8:0]  pos;
    logic        inbuf;
    logic [9:0]  pend;
    logic        ok;
    logic [31:0] ip;
    logic [7:0]  rec [16];
    pos   = dg_len;
    inbuf = (pos < BUF_BYTES);
    if (inbuf) begin
      if (pos == 0 && ((it.src_addr ^ net_cfg) & SENDER_MASK) != 0) hdr_good = 1'b0;
      if (pos == 2 && it.rx_byte[7]) hdr_good = 1'b0;
      if (pos == 4) qd_hi = it.rx_byte;
      if (pos == 5 && (qd_hi != 0 || it.rx_byte != 8'd1)) hdr_good = 1'b0;
      if (!walk_fin && pos == label_pos) begin
        if (it.rx_byte == 0) begin
          walk_fin = 1'b1;
          q_end    = pos + 9'd5;
        end else begin
          label_pos = label_pos + it.rx_byte + 9'd1;
          if (label_pos > WALK_LIMIT) begin
            walk_fin = 1'b1;
            q_end    = label_pos + 9'd5;
          end
        end
      end
      dg_len = pos + 9'd1;
    end

    if (!it.rx_last) begin
      if (keep && inbuf && (!walk_fin || pos < q_end))
        answer_q.push_back('{patch_header(pos, it.rx_byte), 1'b0, 1'b0});
      return;
    end

    // close of datagram: an unfinished walk counts as a question past the end
    pend = walk_fin ? {1'b0, q_end} : ({1'b0, label_pos} + 10'd5);
    ok   = (dg_len >= 12) && hdr_good && (pend <= {1'b0, dg_len}) &&
           ((pend + 10'd16) <= BUF_BYTES);
    if (keep) begin
      if (!ok) begin
        answer_q.push_back(DISCARD_BEAT);
      end else begin
        ip      = net_cfg | 32'd1;
        rec[0]  = NAME_PTR_HI;  rec[1]  = NAME_PTR_LO;
        rec[2]  = 8'h00;        rec[3]  = 8'h01;        // type A
        rec[4]  = 8'h00;        rec[5]  = 8'h01;        // class IN
        rec[6]  = 8'h00;        rec[7]  = 8'h00;
        rec[8]  = 8'h00;        rec[9]  = TTL_SECONDS;
        rec[10] = 8'h00;        rec[11] = RDLENGTH_A;
        rec[12] = ip[31:24];    rec[13] = ip[23:16];
        rec[14] = ip[15:8];     rec[15] = ip[7:0];
        if (inbuf && {1'b0, pos} < pend)
          answer_q.push_back('{patch_header(pos, it.rx_byte), 1'b0, 1'b0});
        for (int i = 0; i < 16; i++) answer_q.push_back('{rec[i], (i == 15), 1'b0});
      end
    end
    dg_len    = '0;
    label_pos = 9'd12;
    q_end     = '0;
    walk_fin  = 1'b0;
    hdr_good  = 1'b1;
    qd_hi     = '0;
  endfunction

  function automatic logic sender_rests();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(99) < 62;
      IDLE_BOTH: return $urandom_range(99) < 19;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic logic receiver_stalls();
    case (idle_mode)
      IDLE_RECV: return $urandom_range(99) < 62;
      IDLE_BOTH: return $urandom_range(99) < 19;
      default:   return 1'b0;
    endcase
  endfunction

  task automatic check_tx_beat(input tx_item_t got);
    tx_item_t want;
    if (answer_q.size() == 0) begin
      flag_mismatch($sformatf("unexpected beat %p", got));
      return;
    end
    want = answer_q.pop_front();
    if (got.tx_byte !== want.tx_byte)
      flag_mismatch($sformatf("tx_byte %h, want %h", got.tx_byte, want.tx_byte));
    if (got.tx_last !== want.tx_last)
      flag_mismatch($sformatf("tx_last %b, want %b", got.tx_last, want.tx_last));
    if (got.tx_discard !== want.tx_discard)
      flag_mismatch($sformatf("tx_discard %b, want %b", got.tx_discard, want.tx_discard));
  endtask

  // Offers one query byte and returns once it has been taken. push stays high
  // between back-to-back beats; it only drops during a gap.
  task automatic drive_query_byte(input rx_item_t it, input logic want_discard);
    while (sender_rests()) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    rx_i <= it;
    do @(posedge clk_i); while (full);
    predict_response(it, !want_discard);
    if (want_discard) answer_q.push_back(DISCARD_BEAT);
    items_sent++;
  endtask

  task automatic build_query(input dg_kind_e kind, ref logic [7:0] dg [$],
                             output logic [31:0] src);
    int          nlab;
    int          len;
    int          qlen;
    int          cut;
    logic [15:0] qdcount;
    dg.delete();
    src = {net_cfg[31:8], 8'($urandom)};
    if (kind == DG_SHORT || kind == DG_NOISE) begin
      len = (kind == DG_SHORT) ? $urandom_range(1, 11) : $urandom_range(1, 40);
      repeat (len) dg.push_back(8'($urandom));
      if (kind == DG_NOISE) src = $urandom;
      return;
    end
    // plain one-question query header
    repeat (12) dg.push_back(8'($urandom));
    dg[2] = dg[2] & 8'h7F;
    dg[4] = 8'h00;
    dg[5] = 8'h01;
    case (kind)
      DG_LIMIT_SHORT: begin
        // one label long enough to push the walk past its limit
        dg.push_back(8'($urandom_range(189, 255)));
        repeat ($urandom_range(0, 5)) dg.push_back(8'($urandom));
      end
      DG_WALK_BIG: begin
        // walk stops on the limit, question ends at 248: no room left for
        // the record; tail runs past the buffer
        dg.push_back(8'd230);
        while (dg.size() < 258) dg.push_back(8'($urandom));
      end
      default: begin
        nlab = $urandom_range(0, 3);
        repeat (nlab) begin
          len = $urandom_range(1, 20);
          dg.push_back(8'(len));
          repeat (len) dg.push_back(8'($urandom));
        end
        dg.push_back(8'h00);
        repeat (4) dg.push_back(8'($urandom));     // qtype, qclass
        qlen = dg.size();
        repeat ($urandom_range(0, 3)) dg.push_back(8'($urandom));
        case (kind)
          DG_FOREIGN_SRC: src = src ^ {24'($urandom_range(1, 24'hFF_FFFF)), 8'h00};
          DG_RESP_BIT:    dg[2] = dg[2] | 8'h80;
          DG_BAD_COUNT: begin
            qdcount = 16'($urandom);
            if (qdcount == 16'h0001) qdcount = 16'h0101;
            dg[4] = qdcount[15:8];
            dg[5] = qdcount[7:0];
          end
          DG_TRUNCATED: begin
            cut = $urandom_range(13, qlen - 1);
            while (dg.size() > cut) void'(dg.pop_back());
          end
          default: ;
        endcase
      end
    endcase
  endtask

  task automatic send_query(input dg_kind_e kind);
    logic [7:0]  dg [$];
    logic [31:0] src;
    rx_item_t    it;
    build_query(kind, dg, src);
    foreach (dg[i]) begin
      it.rx_byte  = dg[i];
      it.rx_last  = (i == dg.size() - 1);
      it.src_addr = (i == 0) ? src : 32'($urandom);   // later addresses are ignored
      drive_query_byte(it, 1'b0);
    end
  endtask

  function automatic dg_kind_e pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 50) return DG_GOOD;
    if (r < 60) return DG_TRUNCATED;
    if (r < 67) return DG_FOREIGN_SRC;
    if (r < 74) return DG_RESP_BIT;
    if (r < 81) return DG_BAD_COUNT;
    if (r < 87) return DG_SHORT;
    if (r < 93) return DG_LIMIT_SHORT;
    return DG_NOISE;
  endfunction

  // Network is only rewritten with nothing in flight.
  task automatic settle_and_set_net(input logic [31:0] value);
    push <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    net_cfg   = value;
  endtask

  // Receiver: random pops, plus a long hold-off counted here on request.
  initial begin
    int hold_left;
    hold_left = 0;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) check_tx_beat(tx_o);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= !receiver_stalls();
      end
    end
  end

  // Sender and phase control
  initial begin
    logic [31:0] net_val;
    int          start;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    push        = 1'b0;
    rx_i        = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_N; i++) drive_query_byte(DIR_ROWS[i].item, DIR_ROWS[i].want_discard);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       net_val = 32'h0000_0000;
        1:       net_val = 32'hFFFF_FFFF;
        2:       net_val = 32'h0A00_00FE;
        default: net_val = $urandom;
      endcase
      settle_and_set_net(net_val);
      idle_mode = idle_mode_e'(ph % 4);
      // no-idle phase: receiver holds off while the sender keeps offering
      if (ph == 0) hold_req = HOLD_CYCLES;
      if (ph == 1) send_query(DG_WALK_BIG);
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) send_query(pick_kind());
    end

    push <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/cdar_pkg.sv
src/cdar_front.sv
src/cdar_cmd_fifo.sv
src/cdar_back.sv
src/captive_dns_answer_rewriter.sv
tb/sv/tb_top.sv
